FILE: rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Types and constants shared by the BMP stream decoder modules.
// ----------------------------------------------------------------------------
package bsd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXELS = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_SIGNATURE   = 3'd0,
    ERR_SHORT_HDR   = 3'd1,
    ERR_UNSUPPORTED = 3'd2,
    ERR_OFFSET      = 3'd3,
    ERR_TOO_LARGE   = 3'd4,
    ERR_TRUNCATED   = 3'd5
  } err_e;

  // Byte positions in the file at which header fields complete
  localparam logic [31:0] OFF_SIG_FIRST = 32'd0;
  localparam logic [31:0] OFF_SIG_LAST  = 32'd1;
  localparam logic [31:0] OFF_PIX_OFS   = 32'd13;
  localparam logic [31:0] OFF_HDR_SIZE  = 32'd17;
  localparam logic [31:0] OFF_WIDTH     = 32'd21;
  localparam logic [31:0] OFF_HEIGHT    = 32'd25;
  localparam logic [31:0] OFF_PLANES    = 32'd29;
  localparam logic [31:0] OFF_COMPRESS  = 32'd33;
  localparam logic [31:0] OFF_VERDICT   = 32'd53;

  localparam logic [7:0]  SIG_B          = 8'h42;
  localparam logic [7:0]  SIG_M          = 8'h4D;
  localparam logic [31:0] HDR_SIZE_MIN   = 32'd40;
  localparam logic [31:0] PIX_OFS_MIN    = 32'd54;
  localparam logic [15:0] PLANES_ONE     = 16'd1;
  localparam logic [15:0] BPP_24         = 16'd24;
  localparam logic [15:0] BPP_32         = 16'd32;
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
  localparam logic [1:0]  BIP_LAST_24    = 2'd2;
  localparam logic [1:0]  BIP_LAST_32    = 2'd3;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] image_width;
    logic [12:0] image_height;
    err_e        error_code;
    logic        image_end;
  } bsd_result_t;

endpackage

FILE: rtl/bmp_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp_stream_decoder_top
// Streaming decoder for 24/32 bpp uncompressed BMP files, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries the file one byte per request; tuser marks the
//   first byte of a file (restarts the parser) and tlast the final byte.
//   The master channel returns at most one result per byte: a header result
//   with the image size, one pixel result per pixel (column, row with top row
//   zero, B/G/R/A unpacked), or an error code. tuser carries the result kind
//   and tlast flags the result that completes the image.
//   Each result is registered in the result buffer before the master side
//   presents it. Throughput: one byte per cycle while the buffer has room,
//   set by the single pass through the parser state registers and a
//   two-entry result buffer. When the receiver stalls, the buffer holds up
//   to two results and s_axis_tready drops (registered) once both entries
//   are taken; bytes that yield no result still wait for that room.
//   Reset leaves the parser waiting for a first byte; bytes before it are
//   dropped. After an error or a finished image, bytes are dropped until the
//   next first byte.
// ----------------------------------------------------------------------------
module bmp_stream_decoder_top import bsd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // pixel_x, pixel_y, red, green, blue,
                                      // alpha, image_width, image_height,
                                      // error_code, zero fill
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast    // image_end
);

  logic        accept;
  logic        push;
  bsd_result_t result;
  bsd_result_t head;

  assign accept = s_axis_tvalid && s_axis_tready;

  bsd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .file_byte_i  (s_axis_tdata),
    .first_byte_i (s_axis_tuser),
    .last_byte_i  (s_axis_tlast),
    .push_o       (push),
    .result_o     (result)
  );

  bsd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {3'b000, head.error_code, head.image_height, head.image_width,
                         head.alpha, head.blue, head.green, head.red,
                         head.pixel_y, head.pixel_x};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.image_end;

endmodule

FILE: rtl/bsd_parser.sv
// ----------------------------------------------------------------------------
// bsd_parser
// Byte-wise header parser and pixel unpacker; one byte per cycle while accept_i is high.
// ----------------------------------------------------------------------------
module bsd_parser import bsd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  file_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        push_o,
  output bsd_result_t result_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW = $clog2(4 * MAX_WIDTH + 4);

  phase_e          phase_q, phase_d;
  logic [31:0]     bo_q, bo_d;
  logic [31:0]     fs_q, fs_d;
  logic [31:0]     po_q, po_d;
  logic [WW-1:0]   w_q, w_d;
  logic [HW-1:0]   h_q, h_d;
  logic            wbig_q, wbig_d;
  logic            hbig_q, hbig_d;
  logic            top_q, top_d;
  logic            alpha_q, alpha_d;
  logic            fbad_q, fbad_d;
  logic [WW-1:0]   col_q, col_d;
  logic [HW-1:0]   row_q, row_d;
  logic [DW-1:0]   rbc_q, rbc_d;
  logic [1:0]      bip_q, bip_d;
  logic [23:0]     part_q, part_d;
  logic [DW-1:0]   data_q, data_d;
  logic [DW-1:0]   stride_q, stride_d;

  logic [DW-1:0]   data_calc;
  logic [DW-1:0]   stride_sum;
  logic [31:0]     hneg;
  logic [31:0]     bo_inc;
  logic [HW-1:0]   y_row;
  logic [31:0]     x32, y32, w32, h32;
  logic [1:0]      last_bip;
  logic            img_done;
  bsd_result_t     res;
  logic            push;

  // Bytes per row before padding, and the padded stride
  assign data_calc  = alpha_q ? DW'({w_q, 2'b00}) : (DW'({w_q, 1'b0}) + DW'(w_q));
  assign stride_sum = data_calc + DW'(3);

  always_comb begin
    phase_d  = phase_q;
    bo_d     = bo_q;
    fs_d     = fs_q;
    po_d     = po_q;
    w_d      = w_q;
    h_d      = h_q;
    wbig_d   = wbig_q;
    hbig_d   = hbig_q;
    top_d    = top_q;
    alpha_d  = alpha_q;
    fbad_d   = fbad_q;
    col_d    = col_q;
    row_d    = row_q;
    rbc_d    = rbc_q;
    bip_d    = bip_q;
    part_d   = part_q;
    data_d   = data_q;
    stride_d = stride_q;
    res      = '0;
    push     = 1'b0;
    hneg     = '0;
    bo_inc   = '0;
    y_row    = '0;
    x32      = '0;
    y32      = '0;
    w32      = '0;
    h32      = '0;
    last_bip = alpha_q ? BIP_LAST_32 : BIP_LAST_24;
    img_done = 1'b0;

    if (accept_i) begin
      if (first_byte_i) begin
        phase_d = PH_HEADER;
        bo_d    = '0;
        fs_d    = '0;
        po_d    = '0;
        w_d     = '0;
        h_d     = '0;
        wbig_d  = 1'b0;
        hbig_d  = 1'b0;
        top_d   = 1'b0;
        alpha_d = 1'b0;
        fbad_d  = 1'b0;
        col_d   = '0;
        row_d   = '0;
        rbc_d   = '0;
        bip_d   = '0;
        part_d  = '0;
      end

      if (phase_d != PH_IDLE && phase_d != PH_DONE) begin
        unique case (phase_d)
          PH_HEADER: begin
            fs_d = {file_byte_i, fs_d[31:8]};
            unique case (bo_d)
              OFF_SIG_FIRST: part_d = {16'h0, file_byte_i};
              OFF_SIG_LAST: begin
                if (part_d[7:0] != SIG_B || file_byte_i != SIG_M) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_SIGNATURE;
                  phase_d        = PH_DONE;
                  push           = 1'b1;
                end
              end
              OFF_PIX_OFS: po_d = fs_d;
              OFF_HDR_SIZE: begin
                if (fs_d < HDR_SIZE_MIN) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_SHORT_HDR;
                  phase_d        = PH_DONE;
                  push           = 1'b1;
                end
              end
              OFF_WIDTH: begin
                w_d    = fs_d[WW-1:0];
                wbig_d = fs_d > 32'(MAX_WIDTH);
              end
              OFF_HEIGHT: begin
                top_d  = fs_d[31];
                hneg   = 32'd0 - fs_d;
                h_d    = top_d ? hneg[HW-1:0] : fs_d[HW-1:0];
                hbig_d = (top_d ? hneg : fs_d) > 32'(MAX_HEIGHT);
              end
              OFF_PLANES: begin
                if (fs_d[15:0] != PLANES_ONE ||
                    (fs_d[31:16] != BPP_24 && fs_d[31:16] != BPP_32)) begin
                  fbad_d = 1'b1;
                end
                alpha_d = (fs_d[31:16] == BPP_32);
              end
              OFF_COMPRESS: begin
                if (fs_d != COMP_RGB && fs_d != COMP_BITFIELDS) begin
                  fbad_d = 1'b1;
                end
              end
              OFF_VERDICT: begin
                push     = 1'b1;
                res.kind = KIND_ERROR;
                phase_d  = PH_DONE;
                if (fbad_d) begin
                  res.error_code = ERR_UNSUPPORTED;
                end else if (po_d < PIX_OFS_MIN) begin
                  res.error_code = ERR_OFFSET;
                end else if (wbig_d || hbig_d) begin
                  res.error_code = ERR_TOO_LARGE;
                end else begin
                  w32              = 32'(w_d);
                  h32              = 32'(h_d);
                  res.kind         = KIND_HEADER;
                  res.image_width  = w32[12:0];
                  res.image_height = h32[12:0];
                  col_d            = '0;
                  row_d            = '0;
                  rbc_d            = '0;
                  bip_d            = '0;
                  part_d           = '0;
                  data_d           = data_calc;
                  stride_d         = {stride_sum[DW-1:2], 2'b00};
                  if (w_d == '0 || h_d == '0) begin
                    res.image_end = 1'b1;
                  end else begin
                    phase_d = (po_d > PIX_OFS_MIN) ? PH_SKIP : PH_PIXELS;
                  end
                end
              end
              default: ;
            endcase
          end
          PH_SKIP: begin
            bo_inc = bo_d + 32'd1;
            if (bo_inc >= po_d) begin
              phase_d = PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            if (rbc_d < data_q) begin
              case (bip_d)
                2'd0:    part_d = {16'h0, file_byte_i};
                2'd1:    part_d[15:8] = file_byte_i;
                2'd2:    part_d[23:16] = file_byte_i;
                default: ;
              endcase
              if (bip_d >= last_bip) begin
                y_row          = top_d ? row_d : (h_d - HW'(1) - row_d);
                x32            = 32'(col_d);
                y32            = 32'(y_row);
                res.kind       = KIND_PIXEL;
                res.pixel_x    = x32[11:0];
                res.pixel_y    = y32[11:0];
                res.red        = alpha_d ? part_d[23:16] : file_byte_i;
                res.green      = part_d[15:8];
                res.blue       = part_d[7:0];
                res.alpha      = alpha_d ? file_byte_i : ALPHA_OPAQUE;
                push           = 1'b1;
                if (({1'b0, col_d} + (WW+1)'(1) >= {1'b0, w_d}) &&
                    ({1'b0, row_d} + (HW+1)'(1) >= {1'b0, h_d})) begin
                  res.image_end = 1'b1;
                  phase_d       = PH_DONE;
                  img_done      = 1'b1;
                end else begin
                  bip_d = '0;
                  col_d = col_d + WW'(1);
                end
              end else begin
                bip_d = bip_d + 2'd1;
              end
            end
            if (!img_done) begin
              rbc_d = rbc_d + DW'(1);
              if (rbc_d >= stride_q) begin
                rbc_d = '0;
                col_d = '0;
                bip_d = '0;
                row_d = row_d + HW'(1);
              end
            end
          end
          default: ;
        endcase

        if (bo_d != '1) begin
          bo_d = bo_d + 32'd1;
        end

        // Drop whatever this byte produced and flag a truncated file
        if (last_byte_i && phase_d != PH_DONE) begin
          res            = '0;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
          phase_d        = PH_DONE;
          push           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bo_q     <= '0;
      fs_q     <= '0;
      po_q     <= '0;
      w_q      <= '0;
      h_q      <= '0;
      wbig_q   <= 1'b0;
      hbig_q   <= 1'b0;
      top_q    <= 1'b0;
      alpha_q  <= 1'b0;
      fbad_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      rbc_q    <= '0;
      bip_q    <= '0;
      part_q   <= '0;
      data_q   <= '0;
      stride_q <= '0;
    end else begin
      phase_q  <= phase_d;
      bo_q     <= bo_d;
      fs_q     <= fs_d;
      po_q     <= po_d;
      w_q      <= w_d;
      h_q      <= h_d;
      wbig_q   <= wbig_d;
      hbig_q   <= hbig_d;
      top_q    <= top_d;
      alpha_q  <= alpha_d;
      fbad_q   <= fbad_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rbc_q    <= rbc_d;
      bip_q    <= bip_d;
      part_q   <= part_d;
      data_q   <= data_d;
      stride_q <= stride_d;
    end
  end

  assign push_o   = push;
  assign result_o = res;

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept_i)
    else $error("result produced without an accepted byte");

  a_error_ends_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.kind == KIND_ERROR) |-> phase_d == PH_DONE)
    else $error("error result left the parser active");

  a_header_at_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.kind == KIND_HEADER) |->
      (bo_q == OFF_VERDICT && phase_d != PH_HEADER))
    else $error("header result outside the verdict byte");

endmodule

FILE: rtl/bsd_out_fifo.sv
// ----------------------------------------------------------------------------
// bsd_out_fifo
// Two-entry result buffer: circular memory with read and write pointers, registered ready.
// ----------------------------------------------------------------------------
module bsd_out_fifo import bsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bsd_result_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        take_i,
  output bsd_result_t data_o
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  bsd_result_t   mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          ready_q, ready_d;
  logic          pop;

  assign pop = valid_o && take_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PW'(1);
      count_d  = count_d + CW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PW'(1);
      count_d  = count_d - CW'(1);
    end
    // Ready is the registered form of whether the updated count leaves a free entry
    ready_d = count_d < CW'(FIFO_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      ready_q  <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      ready_q  <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign ready_o = ready_q;
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CW'(FIFO_DEPTH) || pop))
    else $error("result pushed into a full buffer");

  a_ready_means_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> count_q < CW'(FIFO_DEPTH))
    else $error("ready raised with no free entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FIFO_DEPTH))
    else $error("buffer occupancy out of range");

endmodule
